### src/udpq_pkg.sv
// ----------------------------------------------------------------------------
// udpq_pkg
// Types, codes and sizes shared by the UDP port receive queue block.
// ----------------------------------------------------------------------------
`default_nettype none

package udpq_pkg;

    localparam int NUM_PORTS   = 256;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_COPY    = 4096;

    localparam int PORT_W  = $clog2(NUM_PORTS);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W  = PORT_W + QPTR_W;
    localparam int ENTRIES = NUM_PORTS * QUEUE_DEPTH;
    localparam int COPY_W  = 13;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [1:0] MODE_BIND    = 2'd0;
    localparam logic [1:0] MODE_UNBIND  = 2'd1;
    localparam logic [1:0] MODE_ARRIVE  = 2'd2;
    localparam logic [1:0] MODE_RECEIVE = 2'd3;

    localparam logic [15:0] ETH_ARP     = 16'h0806;
    localparam logic [15:0] ETH_IP      = 16'h0800;
    localparam logic [15:0] MIN_ARP_LEN = 16'd42;
    localparam logic [15:0] MIN_IP_LEN  = 16'd34;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] UDP_HDR     = 16'd8;

    localparam logic [3:0] STAT_OK        = 4'd0;
    localparam logic [3:0] STAT_BAD_PORT  = 4'd1;
    localparam logic [3:0] STAT_ALREADY   = 4'd2;
    localparam logic [3:0] STAT_NOT_BOUND = 4'd3;
    localparam logic [3:0] STAT_LIMIT     = 4'd4;
    localparam logic [3:0] STAT_EMPTY     = 4'd5;
    localparam logic [3:0] STAT_ARP       = 4'd6;
    localparam logic [3:0] STAT_RUNT      = 4'd7;
    localparam logic [3:0] STAT_NOT_UDP   = 4'd8;
    localparam logic [3:0] STAT_UNBOUND   = 4'd9;
    localparam logic [3:0] STAT_FULL      = 4'd10;

    localparam logic [2:0] CMD_DONE    = 3'd0;
    localparam logic [2:0] CMD_BIND    = 3'd1;
    localparam logic [2:0] CMD_UNBIND  = 3'd2;
    localparam logic [2:0] CMD_ARRIVE  = 3'd3;
    localparam logic [2:0] CMD_RECEIVE = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] port;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [15:0] udp_length;
        logic [15:0] buffer_handle;
        logic [15:0] max_length;
    } t_in_item;

    typedef struct packed {
        logic [3:0]        status;
        logic [31:0]       result_source_ip;
        logic [15:0]       result_source_port;
        logic [COPY_W-1:0] copy_length;
        logic [15:0]       result_buffer;
    } t_out_item;

    typedef struct packed {
        logic [2:0]        op;
        logic [3:0]        status;
        logic [PORT_W-1:0] port;
        logic [31:0]       source_ip;
        logic [15:0]       source_port;
        logic [15:0]       udp_length;
        logic [15:0]       buffer;
        logic [COPY_W-1:0] limit;
    } t_cmd;

    typedef struct packed {
        logic              bound;
        logic [QPTR_W-1:0] head;
        logic [QCNT_W-1:0] count;
    } t_port_state;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [15:0] udp_length;
        logic [15:0] buffer;
    } t_entry;

endpackage

`default_nettype wire

### src/udpq_front.sv
// ----------------------------------------------------------------------------
// udpq_front
// Classifies an incoming request and resolves every outcome that does not
// depend on per-port state.
// ----------------------------------------------------------------------------
`default_nettype none

module udpq_front
    import udpq_pkg::*;
(
    input  t_in_item i_item,
    output t_cmd     o_cmd
);

    logic port_ok;
    logic is_arp;
    logic is_ip;

    assign port_ok = 32'(i_item.port) < NUM_PORTS;
    assign is_arp  = (i_item.frame_length >= MIN_ARP_LEN) && (i_item.ether_type == ETH_ARP);
    assign is_ip   = (i_item.frame_length >= MIN_IP_LEN) && (i_item.ether_type == ETH_IP);

    always_comb begin
        o_cmd             = '0;
        o_cmd.port        = i_item.port[PORT_W-1:0];
        o_cmd.source_ip   = i_item.source_ip;
        o_cmd.source_port = i_item.source_port;
        o_cmd.udp_length  = i_item.udp_length;
        o_cmd.limit       = i_item.max_length[COPY_W-1:0];
        o_cmd.status      = STAT_OK;
        unique case (i_item.mode)
            MODE_BIND, MODE_UNBIND: begin
                if (!port_ok) begin
                    o_cmd.op     = CMD_DONE;
                    o_cmd.status = STAT_BAD_PORT;
                end else begin
                    o_cmd.op = (i_item.mode == MODE_BIND) ? CMD_BIND : CMD_UNBIND;
                end
            end
            MODE_ARRIVE: begin
                o_cmd.buffer = i_item.buffer_handle;
                o_cmd.op     = CMD_DONE;
                if (is_arp) begin
                    o_cmd.status = STAT_ARP;
                end else if (!is_ip) begin
                    o_cmd.status = STAT_RUNT;
                end else if (i_item.ip_protocol != PROTO_UDP) begin
                    o_cmd.status = STAT_NOT_UDP;
                end else if (!port_ok) begin
                    o_cmd.status = STAT_UNBOUND;
                end else begin
                    o_cmd.op = CMD_ARRIVE;
                end
            end
            MODE_RECEIVE: begin
                o_cmd.op = CMD_DONE;
                if (i_item.max_length > 16'(MAX_COPY)) begin
                    o_cmd.status = STAT_LIMIT;
                end else if (!port_ok) begin
                    o_cmd.status = STAT_BAD_PORT;
                end else begin
                    o_cmd.op = CMD_RECEIVE;
                end
            end
            default: o_cmd.op = CMD_DONE;
        endcase
    end

endmodule

`default_nettype wire

### src/udpq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// udpq_cmd_fifo
// Short command queue between the classifier and the port engine.
// ----------------------------------------------------------------------------
`default_nettype none

module udpq_cmd_fifo
    import udpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = r_count == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/udpq_back.sv
// ----------------------------------------------------------------------------
// udpq_back
// Port engine: reads per-port state, applies bind, unbind, enqueue and
// dequeue, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module udpq_back
    import udpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_DECIDE  = 2'd1;
    localparam logic [1:0] S_READOUT = 2'd2;

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    t_cmd           r_cmd;

    t_port_state    r_pst_mem [NUM_PORTS];
    t_port_state    r_pst_q;
    logic           r_pst_vq;
    logic [NUM_PORTS-1:0] r_pvalid;
    t_entry         r_ent_mem [ENTRIES];
    t_entry         r_ent_q;

    logic           r_out_valid;
    t_out_item      r_out;

    t_port_state    pst;
    t_port_state    pst_wdata;
    logic           pst_re;
    logic           pst_we;
    logic           ent_we;
    logic           ent_re;
    logic [QPTR_W-1:0] ent_ptr;
    logic [SLOT_W-1:0] slot;
    logic           emit;
    logic           out_free;
    t_out_item      res;
    logic [15:0]    payload_len;
    logic [COPY_W-1:0] copy_len;
    t_entry         ent_wdata;

    assign out_free = !r_out_valid || !i_out_stall;
    assign slot     = {r_cmd.port, ent_ptr};

    assign ent_wdata.source_ip   = r_cmd.source_ip;
    assign ent_wdata.source_port = r_cmd.source_port;
    assign ent_wdata.udp_length  = r_cmd.udp_length;
    assign ent_wdata.buffer      = r_cmd.buffer;

    assign payload_len = (r_ent_q.udp_length < UDP_HDR) ? 16'd0 : r_ent_q.udp_length - UDP_HDR;
    assign copy_len    = (payload_len > 16'(r_cmd.limit)) ? r_cmd.limit
                                                          : payload_len[COPY_W-1:0];

    always_comb begin
        pst       = r_pst_vq ? r_pst_q : '0;
        pst_wdata = pst;
        pst_re    = 1'b0;
        pst_we    = 1'b0;
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_ptr   = pst.head;
        emit      = 1'b0;
        o_cmd_pop = 1'b0;
        res       = '0;
        n_state   = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    pst_re    = 1'b1;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    res.status = r_cmd.status;
                    n_state    = S_IDLE;
                    unique case (r_cmd.op)
                        CMD_BIND: begin
                            if (pst.bound) begin
                                res.status = STAT_ALREADY;
                            end else begin
                                pst_we          = 1'b1;
                                pst_wdata       = '0;
                                pst_wdata.bound = 1'b1;
                                res.status      = STAT_OK;
                            end
                        end
                        CMD_UNBIND: begin
                            pst_we     = 1'b1;
                            pst_wdata  = '0;
                            res.status = STAT_OK;
                        end
                        CMD_ARRIVE: begin
                            ent_ptr = pst.head + pst.count[QPTR_W-1:0];
                            if (!pst.bound) begin
                                res.status        = STAT_UNBOUND;
                                res.result_buffer = r_cmd.buffer;
                            end else if (pst.count >= QCNT_W'(QUEUE_DEPTH)) begin
                                res.status        = STAT_FULL;
                                res.result_buffer = r_cmd.buffer;
                            end else begin
                                ent_we          = 1'b1;
                                pst_we          = 1'b1;
                                pst_wdata.count = pst.count + 1'b1;
                                res.status      = STAT_OK;
                            end
                        end
                        CMD_RECEIVE: begin
                            if (!pst.bound) begin
                                res.status = STAT_NOT_BOUND;
                            end else if (pst.count == '0) begin
                                res.status = STAT_EMPTY;
                            end else begin
                                ent_re          = 1'b1;
                                pst_we          = 1'b1;
                                pst_wdata.head  = pst.head + 1'b1;
                                pst_wdata.count = pst.count - 1'b1;
                                emit            = 1'b0;
                                n_state         = S_READOUT;
                            end
                        end
                        default: res.result_buffer = r_cmd.buffer;
                    endcase
                end
            end
            S_READOUT: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    res.status             = STAT_OK;
                    res.result_source_ip   = r_ent_q.source_ip;
                    res.result_source_port = r_ent_q.source_port;
                    res.copy_length        = copy_len;
                    res.result_buffer      = r_ent_q.buffer;
                    n_state                = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pst_we) begin
            r_pst_mem[r_cmd.port] <= pst_wdata;
        end
        if (pst_re) begin
            r_pst_q <= r_pst_mem[i_cmd.port];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
            r_pst_vq <= 1'b0;
        end else begin
            if (pst_we) begin
                r_pvalid[r_cmd.port] <= 1'b1;
            end
            if (pst_re) begin
                r_pst_vq <= r_pvalid[i_cmd.port];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[slot] <= ent_wdata;
        end
        if (ent_re) begin
            r_ent_q <= r_ent_mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

### src/udp_port_receive_queues.sv
// ----------------------------------------------------------------------------
// udp_port_receive_queues
// UDP port demultiplexer with a 16-entry receive queue per port.
// ----------------------------------------------------------------------------
// Every request (bind, unbind, frame arrival, receive) gives exactly one
// result, in request order. The front classifies a request in the cycle it is
// accepted and places it in a four-entry command queue; requests keep being
// accepted while that queue has room. The port engine takes one request at a
// time, with a read-modify-write of the per-port head/count memory (read in
// S_IDLE, decide and write back in S_DECIDE, which waits out a result stall);
// a successful receive adds S_READOUT for the registered descriptor memory
// read. Per-port state is valid-bit tracked: no clearing pass after reset.
`default_nettype none

module udp_port_receive_queues
    import udpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;

    udpq_front u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd)
    );

    udpq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    udpq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall = q_full;

endmodule

`default_nettype wire

### src/udpq_checker.sv
// ----------------------------------------------------------------------------
// udpq_checker
// Port-level checks on the result channel of the receive queue block.
// ----------------------------------------------------------------------------
`default_nettype none

module udpq_checker
    import udpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      o_out_valid,
    input  logic      i_out_stall,
    input  t_out_item o_out_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= STAT_FULL)
        else $error("status code out of range");

    a_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.copy_length <= COPY_W'(MAX_COPY))
        else $error("copy length above limit");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != STAT_OK |->
            o_out_item.result_source_ip == '0 && o_out_item.result_source_port == '0
            && o_out_item.copy_length == '0)
        else $error("failed request carries receive data");

endmodule

bind udp_port_receive_queues udpq_checker u_checker (.*);

`default_nettype wire
